// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker module cmnu_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, masked while reset is low.
`define CMNU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define CMNU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cmnu_pkg.sv =====
`timescale 1ns / 1ps
package cmnu_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int IDX_W            = 6;
    localparam int CNT_W            = 7;
    localparam int ACT_W            = 2;
    localparam int COST_W           = 32;
    localparam int MASK_W           = 64;
    localparam int IN_DATA_W        = 112;
    localparam int OUT_DATA_W       = 40;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [CNT_W-1:0]  VCOUNT_RESET = 7'd64;
    localparam logic [COST_W-1:0] INT_MAX      = 32'h7FFF_FFFF;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic load;      // item accepted
        logic scan;      // issue one row read of the query
        logic cap_read;  // read data is ready for the result
        logic load_out;  // move result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic in_read;
        logic in_query;
        logic in_err;
        logic scan_end;
    } t_dp_status;

endpackage

// ===== sv/cmnu_ctrl.sv =====
`timescale 1ns / 1ps
module cmnu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  cmnu_pkg::t_dp_status i_status,
    output cmnu_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.load     = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_status.in_err) begin
                        n_state = S_FIN;
                    end else if (i_status.in_read) begin
                        n_state = S_READ;
                    end else if (i_status.in_query) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_READ: begin
                o_cmd.cap_read = 1'b1;
                n_state        = S_FIN;
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/cmnu_dp.sv =====
`timescale 1ns / 1ps
module cmnu_dp #(
    parameter int MAX_VERTICES = cmnu_pkg::MAX_VERTICES_DEF
) (
    input  logic                                  i_clk,
    input  logic [cmnu_pkg::CNT_W-1:0]            i_vertex_count,
    input  logic [cmnu_pkg::ACT_W-1:0]            i_action,
    input  logic [cmnu_pkg::IDX_W-1:0]            i_from_vertex,
    input  logic [cmnu_pkg::IDX_W-1:0]            i_to_vertex,
    input  logic signed [cmnu_pkg::COST_W-1:0]    i_cost_value,
    input  logic [cmnu_pkg::MASK_W-1:0]           i_excluded_mask,
    input  cmnu_pkg::t_dp_cmd                     i_cmd,
    output cmnu_pkg::t_dp_status                  o_status,
    output logic signed [cmnu_pkg::COST_W-1:0]    o_cost_out,
    output logic [cmnu_pkg::IDX_W-1:0]            o_best_vertex,
    output logic                                  o_status_bit
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int DEPTH = (2 ** VW) * (2 ** VW);

    logic [cmnu_pkg::COST_W-1:0] mem [DEPTH];

    logic [cmnu_pkg::CNT_W-1:0]         eff_count;
    logic                               from_bad, to_bad, err;
    logic [2*VW-1:0]                    rd_addr;
    logic [cmnu_pkg::COST_W-1:0]        r_rd_data;
    logic [VW-1:0]                      r_from;
    logic [MAX_VERTICES-1:0]            r_mask;
    logic [cmnu_pkg::CNT_W-1:0]         r_col;
    logic                               r_cmp_valid;
    logic [VW-1:0]                      r_cmp_col;
    logic signed [cmnu_pkg::COST_W-1:0] r_lowest;
    logic [VW-1:0]                      r_best;
    logic signed [cmnu_pkg::COST_W-1:0] r_res_cost;
    logic                               r_res_err;
    logic signed [cmnu_pkg::COST_W-1:0] r_out_cost;
    logic [cmnu_pkg::IDX_W-1:0]         r_out_best;
    logic                               r_out_err;
    logic                               take;

    assign eff_count = (i_vertex_count > cmnu_pkg::CNT_W'(MAX_VERTICES))
                     ? cmnu_pkg::CNT_W'(MAX_VERTICES) : i_vertex_count;
    assign from_bad = {1'b0, i_from_vertex} >= eff_count;
    assign to_bad   = {1'b0, i_to_vertex} >= eff_count;

    always_comb begin
        unique case (cmnu_pkg::t_action'(i_action)) inside
            cmnu_pkg::ACT_WRITE, cmnu_pkg::ACT_READ: err = from_bad || to_bad;
            cmnu_pkg::ACT_QUERY:                     err = from_bad;
            default:                                 err = 1'b0;
        endcase
    end

    assign o_status.in_read  = (i_action == cmnu_pkg::ACT_READ);
    assign o_status.in_query = (i_action == cmnu_pkg::ACT_QUERY);
    assign o_status.in_err   = err;
    assign o_status.scan_end = (r_col == eff_count);

    assign rd_addr = i_cmd.scan ? {r_from, r_col[VW-1:0]}
                                : {i_from_vertex[VW-1:0], i_to_vertex[VW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !err && i_action == cmnu_pkg::ACT_WRITE) begin
            mem[{i_from_vertex[VW-1:0], i_to_vertex[VW-1:0]}] <= i_cost_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    // scan: issue stage, then compare stage on the returned entry
    assign take = r_cmp_valid && !r_mask[r_cmp_col]
                && ($signed(r_rd_data) < r_lowest);

    always_ff @(posedge i_clk) begin
        r_cmp_valid <= i_cmd.scan;
        r_cmp_col   <= r_col[VW-1:0];
        if (i_cmd.load) begin
            r_from     <= i_from_vertex[VW-1:0];
            r_mask     <= i_excluded_mask[MAX_VERTICES-1:0];
            r_col      <= '0;
            r_lowest   <= cmnu_pkg::INT_MAX;
            r_best     <= '0;
            r_res_cost <= '0;
            r_res_err  <= err;
        end else begin
            if (i_cmd.scan) begin
                r_col <= r_col + 1'b1;
            end
            if (take) begin
                r_lowest <= $signed(r_rd_data);
                r_best   <= r_cmp_col;
            end
            if (i_cmd.cap_read) begin
                r_res_cost <= $signed(r_rd_data);
            end
        end
        if (i_cmd.load_out) begin
            r_out_cost <= r_res_cost;
            r_out_best <= cmnu_pkg::IDX_W'(r_best);
            r_out_err  <= r_res_err;
        end
    end

    assign o_cost_out    = r_out_cost;
    assign o_best_vertex = r_out_best;
    assign o_status_bit  = r_out_err;

endmodule

// ===== sv/cost_matrix_nearest_unvisited_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Contents
// s stream | in        | tdata: action, from_vertex, to_vertex, cost_value, excluded_mask
// m stream | out       | tdata: cost_out, best_vertex, status
// apb      | in/out    | vertex_count at byte address 0
//
// Write, none or error: S_IDLE goes straight to S_FIN. Read: S_READ takes the RAM word.
// Query: min(vertex_count, MAX_VERTICES) row entries, one row entry per cycle from the cost RAM.
// Next item is taken once the result is in the output register.
// Reset clears control and sets vertex_count to 64; the RAM is not cleared.
// A stalled result holds the output register; a finished item then waits.
module cost_matrix_nearest_unvisited_unit #(
    parameter int MAX_VERTICES = cmnu_pkg::MAX_VERTICES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [1:0] action, [7:2] from_vertex, [13:8] to_vertex, [45:14] cost_value,
    // [109:46] excluded_mask, [111:110] zero
    input  logic [cmnu_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [31:0] cost_out, [37:32] best_vertex, [38] status, [39] zero
    output logic [cmnu_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cmnu_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cmnu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cmnu_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic [cmnu_pkg::CNT_W-1:0]         r_vertex_count;
    logic                               reg_hit;
    cmnu_pkg::t_dp_cmd                  cmd;
    cmnu_pkg::t_dp_status               status;
    logic signed [cmnu_pkg::COST_W-1:0] cost_out;
    logic [cmnu_pkg::IDX_W-1:0]         best_vertex;
    logic                               status_bit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == cmnu_pkg::REG_VERTEX_COUNT);
    assign prdata  = reg_hit ? cmnu_pkg::APB_DATA_W'(r_vertex_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= cmnu_pkg::VCOUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_vertex_count <= pwdata[cmnu_pkg::CNT_W-1:0];
        end
    end

    cmnu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cmnu_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_vertex_count  (r_vertex_count),
        .i_action        (i_s_tdata[1:0]),
        .i_from_vertex   (i_s_tdata[7:2]),
        .i_to_vertex     (i_s_tdata[13:8]),
        .i_cost_value    (i_s_tdata[45:14]),
        .i_excluded_mask (i_s_tdata[109:46]),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_cost_out      (cost_out),
        .o_best_vertex   (best_vertex),
        .o_status_bit    (status_bit)
    );

    assign o_m_tdata = {1'b0, status_bit, best_vertex, cost_out};

endmodule

// ===== sv/cmnu_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cmnu_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [cmnu_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    `CMNU_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")
    `CMNU_ASSERT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "result changed while stalled")
    `CMNU_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready, "second item taken while one is in work")
    `CMNU_ASSERT(a_err_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[38] |-> o_m_tdata[37:0] == 38'd0, "error result carries data")
    `CMNU_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid && o_s_tready, "block not idle after reset")

endmodule

bind cost_matrix_nearest_unvisited_unit cmnu_checker u_cmnu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
